// ----- hw/rtl/ngga_pkg.sv -----
// Package for the GGA sentence parser: shared constants and types.
// Depends on nothing; used by every module under hw/rtl.
package ngga_pkg;

  localparam int LineMax    = 255;
  localparam int LineCntW   = 10;
  localparam int FracDigits = 5;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam logic [40:0] Cap40 = 41'h07F_FFFF_FFFF;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_NODOLLAR = 3'd1;
  localparam logic [2:0] ST_CKSUM    = 3'd2;
  localparam logic [2:0] ST_NOTGGA   = 3'd3;
  localparam logic [2:0] ST_FEWFLD   = 3'd4;

  // One classified line end, handed from the front to the back.
  typedef struct packed {
    logic [2:0]      status;
    logic [4:0][39:0] val;  // scaled and signed values of the five slots
  } line_rec_t;

  typedef struct packed {
    logic        act;
    logic        neg;
    logic        frac;
    logic        done;
    logic [3:0]  nfrac;
  } pflags_t;

  // Slot to field number: utc, lat, lon, alt, sats.
  function automatic logic [4:0] slot_field(input int s);
    case (s)
      0: slot_field = 5'd1;
      1: slot_field = 5'd2;
      2: slot_field = 5'd4;
      3: slot_field = 5'd9;
      default: slot_field = 5'd7;
    endcase
  endfunction

  function automatic logic [7:0] gga_head(input logic [2:0] p);
    case (p)
      3'd1: gga_head = "P";
      3'd4: gga_head = "A";
      default: gga_head = "G";
    endcase
  endfunction

  // One saturating step of acc*10 + d.
  function automatic logic [40:0] mac10(input logic [40:0] a, input logic [3:0] d);
    logic [44:0] t;
    t = {4'd0, a} * 45'd10 + {41'd0, d};
    mac10 = (t > {4'd0, Cap40}) ? Cap40 : t[40:0];
  endfunction

  // Power of ten that fills in the fraction digits not received.
  function automatic logic [26:0] fill_scale(input logic [3:0] nf);
    logic [26:0] p;
    p = 27'd1;
    for (int n = 0; n < FracDigits; n++)
      if (4'(n) >= nf) p = p * 27'd10;
    fill_scale = p;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

endpackage

// ----- hw/rtl/nmea_gga_sentence_parser_core.sv -----
// GGA sentence parser top level: one byte per cycle while in_stall is low; a
// line's result passes the snapshot stage, the queue and the output register
// after its line end byte is taken, and waits longer while the output stalls.
// Throughput: one byte every cycle unless in_stall is high; in_stall rises
// while two or more results wait in the queue.
// Synchronous reset clears the line state and the stored fix to zero.
module nmea_gga_sentence_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status,
  output logic signed [39:0]  utc_hms,
  output logic signed [39:0]  latitude,
  output logic signed [39:0]  longitude,
  output logic signed [39:0]  altitude,
  output logic signed [7:0]   satellites
);

  logic                rec_valid, q_valid, q_pop;
  ngga_pkg::line_rec_t rec, q_data;
  logic [ngga_pkg::QueuePtrW:0] q_count;
  logic [4:0][39:0]    held;
  logic                acc_in;

  // keep two entries free for the snapshot stage in flight
  assign in_stall = q_count >= (ngga_pkg::QueuePtrW+1)'(ngga_pkg::QueueDepth - 2);
  assign acc_in   = in_valid && !in_stall;

  ngga_front u_front (.clk, .rst, .in_valid(acc_in), .in_byte(rx_byte),
                      .rec_valid, .rec);
  ngga_queue u_queue (.clk, .rst, .wr_en(rec_valid), .wr_data(rec), .rd_en(q_pop),
                      .rd_valid(q_valid), .rd_data(q_data), .count(q_count));
  ngga_back  u_back  (.clk, .rst, .q_valid, .q_data, .q_pop, .out_valid, .out_stall,
                      .status, .held);

  assign utc_hms    = held[0];
  assign latitude   = held[1];
  assign longitude  = held[2];
  assign altitude   = held[3];
  assign satellites = held[4][7:0];

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(rec_valid && q_count == (ngga_pkg::QueuePtrW+1)'(ngga_pkg::QueueDepth)))
    else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ngga_pkg::ST_FEWFLD))
    else $error("status out of range");
`endif

endmodule

// ----- hw/rtl/ngga_front.sv -----
// Front end: byte scanning, checksum, header, field accumulation.
// Depends on ngga_pkg. Emits one line record per non-empty line end.
module ngga_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                rec_valid,
  output ngga_pkg::line_rec_t rec
);

  logic [ngga_pkg::LineCntW-1:0] line_count;
  logic        dollar_seen, star_seen, field_fresh;
  logic [7:0]  xor_sum;
  logic [3:0]  header_pos_ok;
  logic [9:0]  hex_received;
  logic [4:0]  comma_count;
  logic [1:0]  hemi;
  logic [4:0][40:0]      acc;
  ngga_pkg::pflags_t [4:0] pf;

  // Stage 1: end-of-line snapshot, scaled on its way into the queue
  logic        s1_valid;
  logic [2:0]  s1_status;
  logic [4:0][40:0] s1_mag;
  logic [4:0][3:0]  s1_nf;
  logic [4:0]       s1_neg;
  logic [1:0]       s1_hemi;

  logic        is_eol, keep;
  logic [3:0]  hv;
  logic        hv_ok;
  logic [2:0]  stat;

  assign is_eol = (in_byte == 8'h0D) || (in_byte == 8'h0A);
  assign keep   = line_count < ngga_pkg::LineCntW'(ngga_pkg::LineMax);

  // hex digit decode
  always_comb begin
    hv = 4'd0; hv_ok = 1'b1;
    if (ngga_pkg::is_digit(in_byte)) hv = 4'(in_byte - "0");
    else if (in_byte >= "A" && in_byte <= "F") hv = 4'(in_byte - "A" + 8'd10);
    else if (in_byte >= "a" && in_byte <= "f") hv = 4'(in_byte - "a" + 8'd10);
    else hv_ok = 1'b0;
  end

  // status of the line being closed
  always_comb begin
    if (!dollar_seen) stat = ngga_pkg::ST_NODOLLAR;
    else if (!star_seen || hex_received[9:8] != 2'd2 || hex_received[7:0] != xor_sum)
      stat = ngga_pkg::ST_CKSUM;
    else if (header_pos_ok[2:0] != 3'd5 || header_pos_ok[3]) stat = ngga_pkg::ST_NOTGGA;
    else if (comma_count < 5'd10) stat = ngga_pkg::ST_FEWFLD;
    else stat = ngga_pkg::ST_STORED;
  end

  // line scanner
  always_ff @(posedge clk) begin
    if (rst || (in_valid && is_eol)) begin
      line_count <= '0; dollar_seen <= 1'b0; star_seen <= 1'b0; field_fresh <= 1'b0;
      xor_sum <= '0; header_pos_ok <= '0; hex_received <= '0; comma_count <= '0;
      hemi <= '0; acc <= '0; pf <= '0;
    end else if (in_valid && keep) begin
      line_count <= line_count + 1'b1;
      if (!dollar_seen) begin
        if (in_byte == "$") dollar_seen <= 1'b1;
      end else if (star_seen) begin
        if (hex_received[9:8] < 2'd2) begin
          if (!hv_ok) hex_received <= 10'h300;
          else hex_received <= {hex_received[9:8] + 2'd1, hex_received[3:0], hv};
        end
      end else if (in_byte == "*") begin
        star_seen <= 1'b1;
      end else begin
        xor_sum <= xor_sum ^ in_byte;
        if (header_pos_ok[2:0] < 3'd5)
          header_pos_ok <= {header_pos_ok[3] |
                            (in_byte != ngga_pkg::gga_head(header_pos_ok[2:0])),
                            header_pos_ok[2:0] + 3'd1};
        if (in_byte == ",") begin
          if (comma_count < 5'd19) comma_count <= comma_count + 5'd1;
          field_fresh <= 1'b1;
        end else begin
          if (field_fresh) begin
            if (comma_count == 5'd3 && in_byte == "S") hemi[0] <= 1'b1;
            if (comma_count == 5'd5 && in_byte == "W") hemi[1] <= 1'b1;
            field_fresh <= 1'b0;
          end
          for (int s = 0; s < 5; s++) begin
            if (ngga_pkg::slot_field(s) == comma_count && !pf[s].done) begin
              if (!pf[s].act && (in_byte == " " ||
                  (in_byte >= 8'h09 && in_byte <= 8'h0D))) begin
                // skip leading blank
              end else if (!pf[s].act && (in_byte == "+" || in_byte == "-")) begin
                pf[s].act <= 1'b1;
                pf[s].neg <= (in_byte == "-");
              end else begin
                pf[s].act <= 1'b1;
                if (ngga_pkg::is_digit(in_byte)) begin
                  if (!pf[s].frac) acc[s] <= ngga_pkg::mac10(acc[s], in_byte[3:0]);
                  else if (pf[s].nfrac < 4'(ngga_pkg::FracDigits)) begin
                    acc[s] <= ngga_pkg::mac10(acc[s], in_byte[3:0]);
                    pf[s].nfrac <= pf[s].nfrac + 4'd1;
                  end
                end else if (in_byte == "." && !pf[s].frac && s != 4) begin
                  pf[s].frac <= 1'b1;
                end else begin
                  pf[s].done <= 1'b1;
                end
              end
            end
          end
        end
      end
    end
  end

  // snapshot of the closing line
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && is_eol && (line_count != '0);
    end
    if (in_valid && is_eol) begin
      s1_status <= stat;
      s1_mag    <= acc;
      s1_hemi   <= hemi;
      for (int s = 0; s < 5; s++) begin
        s1_nf[s]  <= pf[s].nfrac;
        s1_neg[s] <= pf[s].neg;
      end
    end
  end

  // scaling: slots 0-3 fill missing fraction digits by one multiply by a power
  // of ten, saturating, sign and hemisphere as one negation; sats clamps to int8
  always_comb begin
    logic [40:0] m;
    logic [26:0] p;
    logic [67:0] prod;
    logic [39:0] v;
    rec.status = s1_status;
    for (int s = 0; s < 5; s++) begin
      m = s1_mag[s];
      if (s == 4) begin
        p = 27'd1;
        prod = '0;
        if (s1_neg[4]) v = 40'(8'(-((m > 41'd128) ? 8'd128 : m[7:0])));
        else v = 40'((m > 41'd127) ? 8'd127 : m[7:0]);
      end else begin
        p = ngga_pkg::fill_scale(s1_nf[s]);
        prod = {27'd0, m} * {41'd0, p};
        v = (prod > 68'(ngga_pkg::Cap40)) ? ngga_pkg::Cap40[39:0] : prod[39:0];
        if (s1_neg[s] ^ ((s == 1 && s1_hemi[0]) || (s == 2 && s1_hemi[1]))) v = -v;
      end
      rec.val[s] = v;
    end
  end

  assign rec_valid = s1_valid;

endmodule

// ----- hw/rtl/ngga_queue.sv -----
// Short item queue between front and back.
// Depends on ngga_pkg for the record type and depth.
module ngga_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  ngga_pkg::line_rec_t wr_data,
  input  logic                rd_en,
  output logic                rd_valid,
  output ngga_pkg::line_rec_t rd_data,
  output logic [ngga_pkg::QueuePtrW:0] count
);

  ngga_pkg::line_rec_t mem [ngga_pkg::QueueDepth];
  logic [ngga_pkg::QueuePtrW-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr_en) wp <= wp + 1'b1;
      if (rd_en) rp <= rp + 1'b1;
      count <= count + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
    if (wr_en) mem[wp] <= wr_data;
  end

  assign rd_valid = count != '0;
  assign rd_data  = mem[rp];

endmodule

// ----- hw/rtl/ngga_back.sv -----
// Back end: applies stored fixes to the held values and drives the result.
// Depends on ngga_pkg.
module ngga_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  ngga_pkg::line_rec_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status,
  output logic [4:0][39:0]    held
);

  logic [4:0][39:0] fix;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  // update the held fix on a stored line and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fix <= '0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_valid;
      if (q_valid) begin
        status <= q_data.status;
        if (q_data.status == ngga_pkg::ST_STORED) begin
          fix  <= q_data.val;
          held <= q_data.val;
        end else begin
          held <= fix;
        end
      end
    end
  end

endmodule
